// File: sv/resp_command_parser_assert.svh
// Assertion helpers for the request parser.
`ifndef RESP_COMMAND_PARSER_ASSERT_SVH
`define RESP_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RCP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rcp_pkg.sv
package rcp_pkg;

    // Result word kinds, carried on tuser.
    typedef logic [1:0] item_kind_t;
    localparam item_kind_t KIND_DATA  = 2'd0;
    localparam item_kind_t KIND_END   = 2'd1;
    localparam item_kind_t KIND_ABORT = 2'd2;

    // Characters that steer the parser.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Configuration register indexes.
    localparam logic CFG_MAX_ARG_COUNT = 1'b0;
    localparam logic CFG_MAX_BULK_LEN  = 1'b1;

    // Decimal number accumulator: magnitude saturates at 2^32.
    localparam int NUM_W = 33;
    localparam logic [NUM_W-1:0] NUM_LIMIT = {1'b1, 32'd0};

    typedef struct packed {
        logic neg;
        logic dig;
        logic dend;
        logic ovf;
    } num_flags_t;

endpackage

// File: sv/resp_command_parser.sv
// A word accepted on the input waits in the input register and is processed when the result
// register can take a word; its result then goes to the result register; words that make no result leave then.
// Throughput: one input word per cycle. While a result waits for the consumer, the input
// register still takes one more word, then s_tready stays low until the result is taken.
// Reset: aresetn is synchronous and active low; it returns the parser to idle, empties both
// pipeline registers and restores max_arg_count to 1024 and max_bulk_len to 536870912.
module resp_command_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write port.
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_wdata,
    // Request byte stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [7:0] rx_byte
    // Parsed item stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,    // [7:0] data_byte, [23:8] arg_index
    output rcp_pkg::item_kind_t     m_tuser,    // [1:0] item_kind
    output logic                    m_tlast     // command_last
);

    import rcp_pkg::*;

    `include "resp_command_parser_assert.svh"

    // Parser phases.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SKIP    = 3'd1;
    localparam logic [2:0] PH_ARRLEN  = 3'd2;
    localparam logic [2:0] PH_HDR     = 3'd3;
    localparam logic [2:0] PH_BULKLEN = 3'd4;
    localparam logic [2:0] PH_DATA    = 3'd5;
    localparam logic [2:0] PH_TRAIL   = 3'd6;

    // Configuration registers.
    logic [15:0] max_arg_reg;
    logic [31:0] max_bulk_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state.
    logic [2:0]       phase_reg, phase_next;
    logic             cr_reg, cr_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    num_flags_t       flags_reg, flags_next;
    logic [15:0]      exp_args_reg, exp_args_next;
    logic [15:0]      cur_arg_reg, cur_arg_next;
    logic [31:0]      left_reg, left_next;

    // Result register.
    logic        out_valid_reg;
    item_kind_t  out_kind_reg, out_kind_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [15:0] out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;
    logic        emit;

    // The processing step runs whenever the result register can take a word.
    logic advance;
    logic step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Byte classification.
    logic [7:0] b;
    logic       is_digit;
    logic       line_end;

    assign b        = in_byte_reg;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    // A line ends on LF directly after CR.
    assign line_end = cr_reg && (b == CH_LF);

    // One digit of the decimal number: accum * 10 + digit, saturating at 2^32.
    logic [NUM_W+2:0] num_prod;
    logic [NUM_W-1:0] num_acc_step;
    num_flags_t       num_flags_step;

    assign num_prod = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                    + {{(NUM_W-1){1'b0}}, b[3:0] - CH_ZERO[3:0]};

    always_comb begin
        num_acc_step   = acc_reg;
        num_flags_step = flags_reg;
        if (!flags_reg.dend) begin
            if (!flags_reg.dig && (b == CH_MINUS) && !flags_reg.neg) begin
                num_flags_step.neg = 1'b1;
            end else if (!is_digit) begin
                num_flags_step.dend = 1'b1;
            end else begin
                num_flags_step.dig = 1'b1;
                if (!flags_reg.ovf) begin
                    if (num_prod > {3'b000, NUM_LIMIT}) begin
                        num_flags_step.ovf = 1'b1;
                        num_acc_step       = NUM_LIMIT;
                    end else begin
                        num_acc_step = num_prod[NUM_W-1:0];
                    end
                end
            end
        end
    end

    // Header checks on the finished number.
    logic arr_ok;
    logic bulk_ok;
    logic acc_zero;
    logic last_arg;

    assign acc_zero = (acc_reg == '0);
    assign arr_ok   = flags_reg.dig && !flags_reg.ovf && !flags_reg.neg && !acc_zero
                   && (acc_reg <= {{(NUM_W-16){1'b0}}, max_arg_reg});
    // "-0" is a valid zero length; any other negative length is not.
    assign bulk_ok  = flags_reg.dig && !flags_reg.ovf && !(flags_reg.neg && !acc_zero)
                   && (acc_reg <= {{(NUM_W-32){1'b0}}, max_bulk_reg});
    assign last_arg = ({1'b0, cur_arg_reg} + 17'd1) >= {1'b0, exp_args_reg};

    // Idle handling of a byte: a star opens an array, a dollar sign opens a
    // one-argument command, anything else starts a line to skip.
    logic [2:0] idle_phase;
    logic       idle_star;
    logic       idle_dollar;

    assign idle_star   = (b == CH_STAR);
    assign idle_dollar = (b == CH_DOLLAR);
    assign idle_phase  = idle_star ? PH_ARRLEN : (idle_dollar ? PH_BULKLEN : PH_SKIP);

    logic [31:0] left_dec;
    assign left_dec = (left_reg != 32'd0) ? (left_reg - 32'd1) : left_reg;

    always_comb begin
        phase_next    = phase_reg;
        cr_next       = cr_reg;
        acc_next      = acc_reg;
        flags_next    = flags_reg;
        exp_args_next = exp_args_reg;
        cur_arg_next  = cur_arg_reg;
        left_next     = left_reg;
        emit          = 1'b0;
        out_kind_next = KIND_DATA;
        out_byte_next = 8'd0;
        out_idx_next  = cur_arg_reg;
        out_last_next = 1'b0;

        case (phase_reg)
            PH_SKIP: begin
                cr_next = (b == CH_CR);
                if (line_end) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_ARRLEN: begin
                cr_next = (b == CH_CR);
                if (!line_end) begin
                    acc_next   = num_acc_step;
                    flags_next = num_flags_step;
                end else if (arr_ok) begin
                    exp_args_next = acc_reg[15:0];
                    cur_arg_next  = 16'd0;
                    phase_next    = PH_HDR;
                end else begin
                    // Bad counts are dropped without a result.
                    phase_next = PH_IDLE;
                end
            end
            PH_HDR: begin
                if (b == CH_DOLLAR) begin
                    acc_next   = '0;
                    flags_next = '0;
                    cr_next    = 1'b0;
                    phase_next = PH_BULKLEN;
                end else begin
                    // Missing dollar sign: abort, then treat the byte as in idle.
                    emit          = 1'b1;
                    out_kind_next = KIND_ABORT;
                    phase_next    = idle_phase;
                    if (idle_star || idle_dollar) begin
                        acc_next   = '0;
                        flags_next = '0;
                        cr_next    = 1'b0;
                    end else begin
                        cr_next = (b == CH_CR);
                    end
                    if (idle_dollar) begin
                        exp_args_next = 16'd1;
                        cur_arg_next  = 16'd0;
                    end
                end
            end
            PH_BULKLEN: begin
                cr_next = (b == CH_CR);
                if (!line_end) begin
                    acc_next   = num_acc_step;
                    flags_next = num_flags_step;
                end else if (!bulk_ok) begin
                    emit          = 1'b1;
                    out_kind_next = KIND_ABORT;
                    phase_next    = PH_IDLE;
                end else if (acc_zero) begin
                    left_next  = 32'd2;
                    phase_next = PH_TRAIL;
                end else begin
                    left_next  = acc_reg[31:0];
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                emit          = 1'b1;
                out_kind_next = KIND_DATA;
                out_byte_next = b;
                if (left_dec == 32'd0) begin
                    left_next  = 32'd2;
                    phase_next = PH_TRAIL;
                end else begin
                    left_next = left_dec;
                end
            end
            PH_TRAIL: begin
                if (left_reg > 32'd1) begin
                    left_next = left_reg - 32'd1;
                end else begin
                    left_next     = 32'd0;
                    emit          = 1'b1;
                    out_kind_next = KIND_END;
                    out_last_next = last_arg;
                    if (last_arg) begin
                        phase_next = PH_IDLE;
                    end else begin
                        cur_arg_next = cur_arg_reg + 16'd1;
                        phase_next   = PH_HDR;
                    end
                end
            end
            default: begin
                // Idle, and any unused phase code, which behaves as idle.
                phase_next = idle_phase;
                if (idle_star || idle_dollar) begin
                    acc_next   = '0;
                    flags_next = '0;
                    cr_next    = 1'b0;
                end else begin
                    cr_next = (b == CH_CR);
                end
                if (idle_dollar) begin
                    exp_args_next = 16'd1;
                    cur_arg_next  = 16'd0;
                end
            end
        endcase
    end

    // Configuration registers take writes directly; the user must keep the block idle then (unchecked).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_arg_reg  <= 16'd1024;
            max_bulk_reg <= 32'd536870912;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_ARG_COUNT: max_arg_reg  <= cfg_wdata[15:0];
                CFG_MAX_BULK_LEN:  max_bulk_reg <= cfg_wdata;
                default:           max_arg_reg  <= max_arg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state advances once per processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            cr_reg       <= 1'b0;
            acc_reg      <= '0;
            flags_reg    <= '0;
            exp_args_reg <= 16'd0;
            cur_arg_reg  <= 16'd0;
            left_reg     <= 32'd0;
        end else if (step) begin
            phase_reg    <= phase_next;
            cr_reg       <= cr_next;
            acc_reg      <= acc_next;
            flags_reg    <= flags_next;
            exp_args_reg <= exp_args_next;
            cur_arg_reg  <= cur_arg_next;
            left_reg     <= left_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_idx_reg  <= out_idx_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_idx_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Only an argument end can close a command.
    `RCP_ASSERT_NOW(a_last_on_end_only, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_END), !m_tlast, "command_last on a non-end item")

    // Only data items carry a byte.
    `RCP_ASSERT_NOW(a_byte_zero, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_DATA), m_tdata[7:0] == 8'd0, "byte set on non-data item")

    // Inside a command the argument index stays below the argument count.
    `RCP_ASSERT_NOW(a_arg_in_range, aclk, aresetn,
        (phase_reg == PH_HDR) || (phase_reg == PH_DATA) || (phase_reg == PH_TRAIL),
        cur_arg_reg < exp_args_reg, "argument index beyond count")

    // A stalled result is never overwritten by a new one.
    `RCP_ASSERT_NEXT(a_no_overwrite, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && (out_idx_reg == $past(out_idx_reg)),
        "result overwritten while stalled")

endmodule
